/* rtl/hsvps_pkg.sv */
// hsvps_pkg: shared types for the hsva palette sorter
// color record, sort mode codes and sequencer states
// no dependencies
`default_nettype none

package hsvps_pkg;

  // one stored color, packed hue down to alpha
  typedef struct packed {
    logic [15:0] hue;
    logic [15:0] sat;
    logic [15:0] val;
    logic [15:0] alpha;
  } color_t;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_HUE  = 2'd1,
    MODE_SAT  = 2'd2,
    MODE_VAL  = 2'd3
  } sort_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

/* rtl/hsvps_color_ram.sv */
// hsvps_color_ram: palette store, one write port, one registered read port
// depends on hsvps_pkg for color_t
`default_nettype none

module hsvps_color_ram
  import hsvps_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire color_t            wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output color_t                 rdata
);

  color_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/hsvps_compare.sv */
// hsvps_compare: shared multi-key order compare between two colors
// depends on hsvps_pkg for color_t and sort_mode_t
`default_nettype none

module hsvps_compare
  import hsvps_pkg::*;
(
  input  wire color_t     a,
  input  wire color_t     b,
  input  wire sort_mode_t mode,
  output logic            ahead
);

  logic gray_a;
  logic gray_b;

  assign gray_a = (a.sat == 16'd0);
  assign gray_b = (b.sat == 16'd0);

  always_comb begin
    unique case (mode)
      MODE_HUE: begin
        if (gray_a != gray_b) begin
          ahead = !gray_a;
        end else if (!gray_a) begin
          ahead = (a.hue < b.hue);
        end else begin
          ahead = (a.val < b.val);
        end
      end
      MODE_SAT: begin
        if (a.sat != b.sat) begin
          ahead = (a.sat > b.sat);
        end else if (a.val != b.val) begin
          ahead = (a.val > b.val);
        end else begin
          ahead = (a.hue > b.hue);
        end
      end
      MODE_VAL: begin
        if (a.val != b.val) begin
          ahead = (a.val > b.val);
        end else if (a.sat != b.sat) begin
          ahead = (a.sat > b.sat);
        end else begin
          ahead = (a.hue < b.hue);
        end
      end
      default: begin
        // load order: nothing moves ahead
        ahead = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/hsva_palette_sorter.sv */
// hsva_palette_sorter: top level, palette load, selection sequencer, result port
// depends on hsvps_pkg, hsvps_color_ram and hsvps_compare
`default_nettype none

// Colors are loaded one per cycle (start high while busy is low) into a store
// of MAX_COLORS entries; colors that arrive with the store full are dropped and
// flagged through overflowed on every result of that palette. The color marked
// last_color closes the palette: busy rises and the block emits every stored
// color in the order picked by sort_mode, sampled at that closing transfer.
// Each result shows on the out_* ports for exactly one cycle with result_valid
// high; the receiver cannot stall it. Ordering is a stable selection sort done
// by one shared compare unit: for every output slot the sequencer reads the
// whole store through the single read port of the palette memory, compares
// each registered read against the current best, and then emits the best
// color as the result. No clearing pass is needed after reset. sort_mode is
// written through cfg_write/cfg_data; the user must do so only while idle,
// as the block itself does not enforce it.
module hsva_palette_sorter
  import hsvps_pkg::*;
#(
  parameter int MAX_COLORS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_data,
  // color input
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] hue,
  input  wire logic [15:0] saturation,
  input  wire logic [15:0] brightness,
  input  wire logic [15:0] alpha,
  input  wire logic        last_color,
  // sorted results
  output logic             result_valid,
  output logic [15:0]      out_hue,
  output logic [15:0]      out_saturation,
  output logic [15:0]      out_brightness,
  output logic [15:0]      out_alpha,
  output logic             last_result,
  output logic             overflowed
);

  localparam int IDX_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int CNT_W = $clog2(MAX_COLORS + 1);

  state_t state, state_next;

  sort_mode_t sort_mode;      // programmed register
  sort_mode_t run_mode;       // mode sampled when the palette closes

  logic [CNT_W-1:0] count;    // stored colors
  logic             ovf;      // a color was dropped this palette
  logic [CNT_W-1:0] issue_cnt;  // next store entry to read in this pass
  logic [CNT_W-1:0] emit_cnt;   // results already given
  logic             rd_vld;   // read data valid this cycle
  logic [IDX_W-1:0] rd_idx;   // entry that the read data belongs to
  logic [MAX_COLORS-1:0] taken; // entries already emitted
  logic             have_best;
  color_t           best;
  logic [IDX_W-1:0] best_idx;

  // sequencer controls
  logic accept;
  logic store_en;
  logic issue;
  logic pass_done;
  logic final_emit;

  color_t in_color;
  color_t rd_data;
  logic   cmp_before;
  logic   take;

  assign in_color = '{hue: hue, sat: saturation, val: brightness, alpha: alpha};

  // ---------------------------------------------------------------- storage
  hsvps_color_ram #(
    .DEPTH (MAX_COLORS),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (store_en),
    .waddr(count[IDX_W-1:0]),
    .wdata(in_color),
    .raddr(issue_cnt[IDX_W-1:0]),
    .rdata(rd_data)
  );

  // shared compare: does the fresh entry beat the current best
  hsvps_compare u_cmp (
    .a    (rd_data),
    .b    (best),
    .mode (run_mode),
    .ahead(cmp_before)
  );

  // strict compare keeps the lowest index on ties, so the sort is stable
  assign take = rd_vld && !taken[rd_idx] && (!have_best || cmp_before);

  // ---------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && last_color) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // last read of the pass is being evaluated
        if (issue_cnt >= count && rd_vld) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        state_next = final_emit ? ST_IDLE : ST_SCAN;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------- controls
  always_comb begin
    busy       = 1'b1;
    accept     = 1'b0;
    store_en   = 1'b0;
    issue      = 1'b0;
    pass_done  = 1'b0;
    final_emit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        accept   = start;
        store_en = start && (count < CNT_W'(MAX_COLORS));
      end
      ST_SCAN: begin
        issue = (issue_cnt < count);
      end
      ST_EMIT: begin
        pass_done  = 1'b1;
        final_emit = (emit_cnt + CNT_W'(1) == count);
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sort_mode <= MODE_LOAD;
      run_mode  <= MODE_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      issue_cnt <= '0;
      emit_cnt  <= '0;
      rd_vld    <= 1'b0;
      taken     <= '0;
      have_best <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;

      if (cfg_write) begin
        sort_mode <= sort_mode_t'(cfg_data);
      end

      if (accept) begin
        if (store_en) begin
          count <= count + CNT_W'(1);
        end else begin
          ovf <= 1'b1;
        end
        if (last_color) begin
          run_mode  <= sort_mode;
          issue_cnt <= '0;
          emit_cnt  <= '0;
          have_best <= 1'b0;
        end
      end

      if (issue) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end

      if (take) begin
        have_best <= 1'b1;
      end

      if (pass_done) begin
        issue_cnt <= '0;
        have_best <= 1'b0;
        if (final_emit) begin
          // palette done, start again empty
          count    <= '0;
          ovf      <= 1'b0;
          emit_cnt <= '0;
          taken    <= '0;
        end else begin
          emit_cnt        <= emit_cnt + CNT_W'(1);
          taken[best_idx] <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx <= issue_cnt[IDX_W-1:0];
    if (take) begin
      best     <= rd_data;
      best_idx <= rd_idx;
    end
  end

  // ---------------------------------------------------------- result port
  assign result_valid   = (state == ST_EMIT);
  assign out_hue        = best.hue;
  assign out_saturation = best.sat;
  assign out_brightness = best.val;
  assign out_alpha      = best.alpha;
  assign last_result    = final_emit;
  assign overflowed     = ovf;

  // ---------------------------------------------------------- checks
  a_emit_has_best: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> have_best)
    else $error("result emitted without a selected color");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (emit_cnt < count))
    else $error("more results than stored colors");

  a_mark_taken: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_result) |=> taken[$past(best_idx)])
    else $error("emitted entry not marked taken");

  a_close_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last_color) |=> (busy && !result_valid))
    else $error("closing transfer did not start the sort");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_result) |=> (!busy && count == '0 && !ovf))
    else $error("palette state not cleared after final result");

endmodule

`default_nettype wire

/* tb/sv/hsva_palette_sorter_tb.sv */
`timescale 1ns / 1ps
// hsva_palette_sorter_tb: self-checking bench for the hsva palette sorter
// a directed table and random palettes, checked against a stable-sort model
// depends on hsvps_pkg and the hsva_palette_sorter rtl
module hsva_palette_sorter_tb;
  import hsvps_pkg::*;

  localparam int STORE_SIZE  = 64;
  localparam int COLOR_ITEMS = 410;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_ROWS    = 21;

  // one emitted color as seen on the result side
  typedef struct packed {
    color_t color;
    logic   last_r;
    logic   ovf;
  } sorted_color_t;

  // one row of the directed table; want is only meaningful when typed is set
  typedef struct {
    logic          set_mode;
    sort_mode_t    mode;
    color_t        color;
    logic          last;
    logic          typed;
    sorted_color_t want;
  } load_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_data = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] hue = '0;
  logic [15:0] saturation = '0;
  logic [15:0] brightness = '0;
  logic [15:0] alpha = '0;
  logic        last_color = 1'b0;
  logic        result_valid;
  logic [15:0] out_hue;
  logic [15:0] out_saturation;
  logic [15:0] out_brightness;
  logic [15:0] out_alpha;
  logic        last_result;
  logic        overflowed;

  // model state: palette store, fill level, drop flag and the mode register
  color_t        pal_store [STORE_SIZE];
  int            pal_count = 0;
  bit            pal_dropped = 1'b0;
  sort_mode_t    mode_reg = MODE_LOAD;
  sorted_color_t sorted_q [$];

  // run bookkeeping
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int colors_sent = 0;
  int palettes_closed = 0;
  int overflow_palettes = 0;
  int colors_checked = 0;
  int burst_left = 0;
  bit [3:0] modes_seen = '0;

  load_row_t dir_rows [DIR_ROWS];

  always #6 clk = ~clk;

  hsva_palette_sorter u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .start          (start),
    .busy           (busy),
    .hue            (hue),
    .saturation     (saturation),
    .brightness     (brightness),
    .alpha          (alpha),
    .last_color     (last_color),
    .result_valid   (result_valid),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness),
    .out_alpha      (out_alpha),
    .last_result    (last_result),
    .overflowed     (overflowed)
  );

  // strict "a goes ahead of b" for the given order; equal keys return 0,
  // which is what keeps the insertion sort stable
  function automatic bit ranks_ahead(color_t a, color_t b, sort_mode_t m);
    case (m)
      MODE_HUE: begin
        // colored before gray, colored by hue, gray by value
        if ((a.sat == 16'd0) != (b.sat == 16'd0)) return a.sat != 16'd0;
        if (a.sat != 16'd0) return a.hue < b.hue;
        return a.val < b.val;
      end
      MODE_SAT: begin
        if (a.sat != b.sat) return a.sat > b.sat;
        if (a.val != b.val) return a.val > b.val;
        return a.hue > b.hue;
      end
      MODE_VAL: begin
        if (a.val != b.val) return a.val > b.val;
        if (a.sat != b.sat) return a.sat > b.sat;
        return a.hue < b.hue;
      end
      default: return 1'b0;
    endcase
  endfunction

  // apply one accepted color to the model; a closing color sorts the
  // palette and queues every color it will emit
  function automatic void load_color(color_t c, logic closing);
    color_t        ord [STORE_SIZE];
    sorted_color_t res;
    color_t        cur;
    int            j;
    if (pal_count < STORE_SIZE) begin
      pal_store[pal_count] = c;
      pal_count++;
    end else begin
      pal_dropped = 1'b1;
    end
    if (!closing) return;
    for (int i = 0; i < pal_count; i++) begin
      cur = pal_store[i];
      j = i;
      while (j > 0 && ranks_ahead(cur, ord[j-1], mode_reg)) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = cur;
    end
    for (int i = 0; i < pal_count; i++) begin
      res.color  = ord[i];
      res.last_r = (i == pal_count - 1);
      res.ovf    = pal_dropped;
      sorted_q = {sorted_q, res};
    end
    palettes_closed++;
    if (pal_dropped) overflow_palettes++;
    pal_count = 0;
    pal_dropped = 1'b0;
  endfunction

  // field values biased toward the extremes and toward tiny values so that
  // ties between colors show up often; zero saturation gives gray colors
  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 3));
      4: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic color_t rand_color();
    color_t c;
    c.hue   = pick_field();
    c.sat   = pick_field();
    c.val   = pick_field();
    c.alpha = pick_field();
    return c;
  endfunction

  // present one color and hold it until the transfer; busy is sampled
  // before the edge updates land, so it is the value the block acted on
  task automatic send_color(color_t c, logic closing);
    start      <= 1'b1;
    hue        <= c.hue;
    saturation <= c.sat;
    brightness <= c.val;
    alpha      <= c.alpha;
    last_color <= closing;
    @(posedge clk);
    while (busy) @(posedge clk);
    load_color(c, closing);
    colors_sent++;
  endtask

  // sender pacing: bursts of back-to-back transfers split by random gaps,
  // with the odd long gap that spans a whole emission
  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left > 0) return;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 5);
    start <= 1'b0;
    repeat (gap) @(posedge clk);
    // one burst in four runs long with no gaps at all
    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                             : $urandom_range(1, 12);
  endtask

  // mode writes only happen with the block idle: drain every pending
  // result, then a short pause past the last one, then wait on busy
  task automatic set_mode(sort_mode_t m);
    start <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    mode_reg = m;
    modes_seen[m] = 1'b1;
  endtask

  // result side: every strobe is one transfer, matched against the oldest
  // pending color field by field
  always @(posedge clk) begin
    sorted_color_t want;
    if (!rst && result_valid) begin
      if (sorted_q.size() == 0) begin
        $error("unexpected result: hue %h sat %h val %h alpha %h",
               out_hue, out_saturation, out_brightness, out_alpha);
        fail_cnt++;
      end else begin
        want = sorted_q.pop_front();
        colors_checked++;
        if (out_hue !== want.color.hue) begin
          $error("out_hue: expected %h, got %h", want.color.hue, out_hue);
          fail_cnt++;
        end
        if (out_saturation !== want.color.sat) begin
          $error("out_saturation: expected %h, got %h", want.color.sat, out_saturation);
          fail_cnt++;
        end
        if (out_brightness !== want.color.val) begin
          $error("out_brightness: expected %h, got %h", want.color.val, out_brightness);
          fail_cnt++;
        end
        if (out_alpha !== want.color.alpha) begin
          $error("out_alpha: expected %h, got %h", want.color.alpha, out_alpha);
          fail_cnt++;
        end
        if (last_result !== want.last_r) begin
          $error("last_result: expected %b, got %b", want.last_r, last_result);
          fail_cnt++;
        end
        if (overflowed !== want.ovf) begin
          $error("overflowed: expected %b, got %b", want.ovf, overflowed);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog, far above the slowest legal run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("hsva_palette_sorter_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int         size;
    sort_mode_t m;
    bit         forced;
    int         pal_idx;

    // color is packed hue, sat, val, alpha from the top down
    dir_rows = '{
      // straight out of reset, load order: a single color comes back as is
      '{1'b0, MODE_LOAD, 64'h0000_0000_0000_0000, 1'b1, 1'b1,
        {64'h0000_0000_0000_0000, 1'b1, 1'b0}},
      '{1'b0, MODE_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
        {64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0}},
      // by hue: grays after colored, grays by value, equal hues stay in order
      '{1'b1, MODE_HUE,  64'h8000_1234_0100_0001, 1'b0, 1'b0, '0},
      '{1'b0, MODE_LOAD, 64'h0000_0000_0200_0002, 1'b0, 1'b0, '0},
      '{1'b0, MODE_LOAD, 64'h0001_FFFF_0000_0003, 1'b0, 1'b0, '0},
      '{1'b0, MODE_LOAD, 64'hFFFF_0000_0100_0004, 1'b0, 1'b0, '0},
      '{1'b0, MODE_LOAD, 64'h8000_0001_FFFF_0005, 1'b1, 1'b0, '0},
      // by saturation: ties fall to value, then hue, then load order
      '{1'b1, MODE_SAT,  64'h1000_8000_4000_0011, 1'b0, 1'b0, '0},
      '{1'b0, MODE_LOAD, 64'h2000_8000_4000_0012, 1'b0, 1'b0, '0},
      '{1'b0, MODE_LOAD, 64'h0000_8000_8000_0013, 1'b0, 1'b0, '0},
      '{1'b0, MODE_LOAD, 64'h3000_FFFF_0000_0014, 1'b0, 1'b0, '0},
      '{1'b0, MODE_LOAD, 64'h2000_8000_4000_0015, 1'b1, 1'b0, '0},
      // by value: ties fall to saturation, then ascending hue
      '{1'b1, MODE_VAL,  64'h0100_0000_FFFF_0021, 1'b0, 1'b0, '0},
      '{1'b0, MODE_LOAD, 64'h0000_0000_FFFF_0022, 1'b0, 1'b0, '0},
      '{1'b0, MODE_LOAD, 64'h0000_0001_FFFF_0023, 1'b0, 1'b0, '0},
      '{1'b0, MODE_LOAD, 64'hFFFF_FFFF_0000_0024, 1'b0, 1'b0, '0},
      '{1'b0, MODE_LOAD, 64'h0000_0001_FFFF_0025, 1'b1, 1'b0, '0},
      // back to load order
      '{1'b1, MODE_LOAD, 64'hABCD_5555_AAAA_FFFF, 1'b0, 1'b0, '0},
      '{1'b0, MODE_LOAD, 64'h0000_0000_0000_0000, 1'b0, 1'b0, '0},
      '{1'b0, MODE_LOAD, 64'hFFFF_FFFF_FFFF_0000, 1'b1, 1'b0, '0},
      '{1'b0, MODE_LOAD, 64'h1234_5678_9ABC_DEF0, 1'b1, 1'b1,
        {64'h1234_5678_9ABC_DEF0, 1'b1, 1'b0}}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 12);

    // directed table; a typed row replaces the model's entry with its own
    foreach (dir_rows[r]) begin
      if (dir_rows[r].set_mode) set_mode(dir_rows[r].mode);
      send_color(dir_rows[r].color, dir_rows[r].last);
      if (dir_rows[r].typed) begin
        sorted_q[sorted_q.size() - 1] = dir_rows[r].want;
      end
      pace();
    end

    // random palettes, mostly small; three large ones cover a store filled
    // exactly, a closing color that is dropped, and several drops in a row
    pal_idx = 0;
    while (colors_sent < COLOR_ITEMS) begin
      forced = 1'b1;
      case (pal_idx)
        3:  begin size = STORE_SIZE;     m = MODE_VAL;  end
        9:  begin size = STORE_SIZE + 1; m = MODE_LOAD; end
        14: begin size = STORE_SIZE + 6; m = MODE_HUE;  end
        default: begin
          forced = 1'b0;
          size = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
          m = sort_mode_t'($urandom_range(0, 3));
        end
      endcase
      // about half the palettes change mode, each after a full drain
      if (forced || $urandom_range(0, 1)) set_mode(m);
      for (int k = 0; k < size; k++) begin
        send_color(rand_color(), k == size - 1);
        pace();
      end
      pal_idx++;
    end

    // drain, then give the block time to show any stray strobe
    start <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run: %0d colors in %0d palettes (%0d with drops), %0d sorted colors checked",
             colors_sent, palettes_closed, overflow_palettes, colors_checked);
    $display("run: sort modes exercised mask %b", modes_seen);
    if (fail_cnt == 0) begin
      $display("hsva_palette_sorter_tb OK");
    end else begin
      $display("hsva_palette_sorter_tb NOT OK");
    end
    $finish;
  end

endmodule
